// ===== hw/rtl/c6502eu_pkg.sv =====
// Package for the 6502 execute unit: operation codes, payload structs,
// status bit positions and the decoded-operation record. No dependencies.
package c6502eu_pkg;

    typedef enum logic [5:0] {
        OP_NONE = 6'd0,  OP_LDA = 6'd1,  OP_LDX = 6'd2,  OP_LDY = 6'd3,
        OP_STA  = 6'd4,  OP_STX = 6'd5,  OP_STY = 6'd6,  OP_TAX = 6'd7,
        OP_TAY  = 6'd8,  OP_TXA = 6'd9,  OP_TYA = 6'd10, OP_TSX = 6'd11,
        OP_TXS  = 6'd12, OP_PHA = 6'd13, OP_PHP = 6'd14, OP_PLA = 6'd15,
        OP_PLP  = 6'd16, OP_AND = 6'd17, OP_EOR = 6'd18, OP_ORA = 6'd19,
        OP_BIT  = 6'd20, OP_ADC = 6'd21, OP_SBC = 6'd22, OP_CMP = 6'd23,
        OP_CPX  = 6'd24, OP_CPY = 6'd25, OP_INC = 6'd26, OP_INX = 6'd27,
        OP_INY  = 6'd28, OP_DEC = 6'd29, OP_DEX = 6'd30, OP_DEY = 6'd31,
        OP_ASL  = 6'd32, OP_LSR = 6'd33, OP_ROL = 6'd34, OP_ROR = 6'd35,
        OP_JMP  = 6'd36, OP_JSR = 6'd37, OP_RTS = 6'd38, OP_BCC = 6'd39,
        OP_BCS  = 6'd40, OP_BEQ = 6'd41, OP_BMI = 6'd42, OP_BNE = 6'd43,
        OP_BPL  = 6'd44, OP_BVC = 6'd45, OP_BVS = 6'd46, OP_CLC = 6'd47,
        OP_CLD  = 6'd48, OP_CLI = 6'd49, OP_CLV = 6'd50, OP_SEC = 6'd51,
        OP_SED  = 6'd52, OP_SEI = 6'd53, OP_BRK = 6'd54, OP_NOP = 6'd55,
        OP_RTI  = 6'd56
    } t_func;

    localparam int unsigned FL_C = 0;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_I = 2;
    localparam int unsigned FL_D = 3;
    localparam int unsigned FL_B = 4;
    localparam int unsigned FL_U = 5;
    localparam int unsigned FL_V = 6;
    localparam int unsigned FL_N = 7;

    localparam logic [7:0]  SP_RESET     = 8'hFD;
    localparam logic [7:0]  STATUS_RESET = 8'h24;
    localparam logic [7:0]  STACK_PAGE   = 8'h01;

    typedef struct packed {
        logic [5:0]  func;
        logic [7:0]  operand;
        logic [15:0] eff_address;
        logic        page_crossed;
        logic        acc_mode;
        logic [15:0] cur_pc;
        logic [7:0]  stack_above1;
        logic [7:0]  stack_above2;
        logic [7:0]  stack_above3;
        logic [7:0]  vector_low;
        logic [7:0]  vector_high;
    } t_in_item;

    typedef struct packed {
        logic        is_last;
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [15:0] next_pc;
        logic [1:0]  extra_cycles;
        logic [7:0]  acc_out;
        logic [7:0]  x_out;
        logic [7:0]  y_out;
        logic [7:0]  sp_out;
        logic [7:0]  status_out;
    } t_out_item;

    // Classification the front end attaches to each item.
    typedef struct packed {
        t_func       func;
        logic        known;
        logic        page_pen;   // page crossing sets the extra_cycles penalty
        logic        is_branch;
        logic [7:0]  operand;
        logic [15:0] eff_address;
        logic        page_crossed;
        logic        acc_mode;
        logic [15:0] cur_pc;
        logic [7:0]  s1;
        logic [7:0]  s2;
        logic [7:0]  s3;
        logic [15:0] vector;
    } t_dec_item;

endpackage

// ===== hw/rtl/c6502eu_front.sv =====
// Front end: accepts input items, classifies the operation and pushes the
// decoded record into the queue. Depends on c6502eu_pkg.
module c6502eu_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  c6502eu_pkg::t_in_item   i_item,
    output logic                    o_push,
    output c6502eu_pkg::t_dec_item  o_dec,
    input  logic                    i_full
);
    c6502eu_pkg::t_dec_item n_dec;
    logic                   r_unused;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        n_dec              = '0;
        n_dec.func         = c6502eu_pkg::t_func'(i_item.func);
        n_dec.known        = (i_item.func != 6'd0) && (i_item.func <= 6'd56);
        n_dec.page_pen     = (i_item.func >= 6'd1 && i_item.func <= 6'd3) ||
                             (i_item.func >= 6'd17 && i_item.func <= 6'd19) ||
                             (i_item.func >= 6'd21 && i_item.func <= 6'd23);
        n_dec.is_branch    = (i_item.func >= 6'd39) && (i_item.func <= 6'd46);
        n_dec.operand      = i_item.operand;
        n_dec.eff_address  = i_item.eff_address;
        n_dec.page_crossed = i_item.page_crossed;
        n_dec.acc_mode     = i_item.acc_mode;
        n_dec.cur_pc       = i_item.cur_pc;
        n_dec.s1           = i_item.stack_above1;
        n_dec.s2           = i_item.stack_above2;
        n_dec.s3           = i_item.stack_above3;
        n_dec.vector       = {i_item.vector_high, i_item.vector_low};
    end

    assign o_dec = n_dec;

    // Track nothing but a sticky marker of any transfer; keeps the port clocked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unused <= 1'b0;
        end else if (o_push) begin
            r_unused <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full) else $error("push while queue full");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_push) |-> (o_stall && r_unused == r_unused))
        else $error("valid item neither taken nor stalled");
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_unused) else $error("transfer marker not set");
`endif
endmodule

// ===== hw/rtl/c6502eu_queue.sv =====
// Two-entry queue between the front and back ends of the execute unit.
// Depends on c6502eu_pkg.
module c6502eu_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  c6502eu_pkg::t_dec_item  i_data,
    output logic                    o_full,
    input  logic                    i_pop,
    output logic                    o_empty,
    output c6502eu_pkg::t_dec_item  o_data
);
    c6502eu_pkg::t_dec_item r_mem [2];
    logic                   r_wr;
    logic                   r_rd;
    logic [1:0]             r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
`endif
endmodule

// ===== hw/rtl/c6502eu_back.sv =====
// Back end: executes the decoded operation against the register file and
// emits writes then a closing result through an output register. Depends on
// c6502eu_pkg.
module c6502eu_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  c6502eu_pkg::t_dec_item  i_dec,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output c6502eu_pkg::t_out_item  o_item
);
    // Register file
    logic [7:0] r_a, r_x, r_y, r_sp, r_p;
    logic [7:0] n_a, n_x, n_y, n_sp, n_p;

    // Write sequencing for the current item
    logic [1:0] r_step;                // writes already sent
    logic [1:0] n_nwr;                 // writes this item needs
    logic [15:0] n_wa [3];
    logic [7:0]  n_wd [3];
    logic [15:0] n_npc;
    logic [1:0]  n_extra;

    logic                   r_valid;
    c6502eu_pkg::t_out_item r_out;
    c6502eu_pkg::t_out_item n_out;

    logic       out_free;
    logic       have;
    logic       closing;
    logic [8:0] sum;
    logic [7:0] addend;
    logic [7:0] r8;
    logic [7:0] cmp_reg;
    logic [7:0] cmp_diff;
    logic       cond;
    logic [15:0] ret_pc;

    assign out_free = !r_valid || !i_stall;
    assign have     = !i_empty;
    assign closing  = have && out_free && (r_step == n_nwr);
    assign o_pop    = closing;
    assign o_valid  = r_valid;
    assign o_item   = r_out;

    always_comb begin
        n_a = r_a; n_x = r_x; n_y = r_y; n_sp = r_sp; n_p = r_p;
        n_nwr = 2'd0;
        n_wa[0] = i_dec.eff_address; n_wa[1] = 16'd0; n_wa[2] = 16'd0;
        n_wd[0] = 8'd0; n_wd[1] = 8'd0; n_wd[2] = 8'd0;
        n_npc = i_dec.cur_pc;
        n_extra = 2'd0;
        addend = (i_dec.func == c6502eu_pkg::OP_SBC) ? ~i_dec.operand : i_dec.operand;
        sum = {1'b0, r_a} + {1'b0, addend} + {8'd0, r_p[c6502eu_pkg::FL_C]};
        cmp_reg = (i_dec.func == c6502eu_pkg::OP_CPX) ? r_x :
                  (i_dec.func == c6502eu_pkg::OP_CPY) ? r_y : r_a;
        cmp_diff = cmp_reg - i_dec.operand;
        r8 = 8'd0;
        cond = 1'b0;
        ret_pc = 16'd0;
        unique case (i_dec.func)
            c6502eu_pkg::OP_LDA: begin n_a = i_dec.operand; r8 = n_a; end
            c6502eu_pkg::OP_LDX: begin n_x = i_dec.operand; r8 = n_x; end
            c6502eu_pkg::OP_LDY: begin n_y = i_dec.operand; r8 = n_y; end
            c6502eu_pkg::OP_STA: begin n_nwr = 2'd1; n_wd[0] = r_a; end
            c6502eu_pkg::OP_STX: begin n_nwr = 2'd1; n_wd[0] = r_x; end
            c6502eu_pkg::OP_STY: begin n_nwr = 2'd1; n_wd[0] = r_y; end
            c6502eu_pkg::OP_TAX: begin n_x = r_a; r8 = r_a; end
            c6502eu_pkg::OP_TAY: begin n_y = r_a; r8 = r_a; end
            c6502eu_pkg::OP_TXA: begin n_a = r_x; r8 = r_x; end
            c6502eu_pkg::OP_TYA: begin n_a = r_y; r8 = r_y; end
            c6502eu_pkg::OP_TSX: begin n_x = r_sp; r8 = r_sp; end
            c6502eu_pkg::OP_TXS: n_sp = r_x;
            c6502eu_pkg::OP_PHA, c6502eu_pkg::OP_PHP: begin
                n_nwr = 2'd1;
                n_wa[0] = {c6502eu_pkg::STACK_PAGE, r_sp};
                n_wd[0] = (i_dec.func == c6502eu_pkg::OP_PHA) ? r_a : (r_p | 8'h10);
                n_sp = r_sp - 8'd1;
            end
            c6502eu_pkg::OP_PLA: begin n_sp = r_sp + 8'd1; n_a = i_dec.s1; r8 = i_dec.s1; end
            c6502eu_pkg::OP_PLP: begin
                n_sp = r_sp + 8'd1;
                n_p = (i_dec.s1 | 8'h20) & 8'hEF;
            end
            c6502eu_pkg::OP_AND: begin n_a = r_a & i_dec.operand; r8 = n_a; end
            c6502eu_pkg::OP_EOR: begin n_a = r_a ^ i_dec.operand; r8 = n_a; end
            c6502eu_pkg::OP_ORA: begin n_a = r_a | i_dec.operand; r8 = n_a; end
            c6502eu_pkg::OP_BIT: begin
                n_p[c6502eu_pkg::FL_Z] = ((r_a & i_dec.operand) == 8'd0);
                n_p[c6502eu_pkg::FL_V] = i_dec.operand[6];
                n_p[c6502eu_pkg::FL_N] = i_dec.operand[7];
            end
            c6502eu_pkg::OP_ADC, c6502eu_pkg::OP_SBC: begin
                n_a = sum[7:0]; r8 = n_a;
                n_p[c6502eu_pkg::FL_C] = sum[8];
                n_p[c6502eu_pkg::FL_V] = !(r_a[7] ^ addend[7]) && (r_a[7] ^ sum[7]);
            end
            c6502eu_pkg::OP_CMP, c6502eu_pkg::OP_CPX, c6502eu_pkg::OP_CPY: begin
                n_p[c6502eu_pkg::FL_C] = (cmp_reg >= i_dec.operand);
                r8 = cmp_diff;
            end
            c6502eu_pkg::OP_INC, c6502eu_pkg::OP_DEC: begin
                r8 = (i_dec.func == c6502eu_pkg::OP_INC) ? i_dec.operand + 8'd1
                                                         : i_dec.operand - 8'd1;
                n_nwr = 2'd1; n_wd[0] = r8;
            end
            c6502eu_pkg::OP_INX: begin n_x = r_x + 8'd1; r8 = n_x; end
            c6502eu_pkg::OP_INY: begin n_y = r_y + 8'd1; r8 = n_y; end
            c6502eu_pkg::OP_DEX: begin n_x = r_x - 8'd1; r8 = n_x; end
            c6502eu_pkg::OP_DEY: begin n_y = r_y - 8'd1; r8 = n_y; end
            c6502eu_pkg::OP_ASL, c6502eu_pkg::OP_LSR,
            c6502eu_pkg::OP_ROL, c6502eu_pkg::OP_ROR: begin
                if (i_dec.func == c6502eu_pkg::OP_ASL || i_dec.func == c6502eu_pkg::OP_ROL) begin
                    n_p[c6502eu_pkg::FL_C] = i_dec.operand[7];
                    r8 = {i_dec.operand[6:0],
                          (i_dec.func == c6502eu_pkg::OP_ROL) & r_p[c6502eu_pkg::FL_C]};
                end else begin
                    n_p[c6502eu_pkg::FL_C] = i_dec.operand[0];
                    r8 = {(i_dec.func == c6502eu_pkg::OP_ROR) & r_p[c6502eu_pkg::FL_C],
                          i_dec.operand[7:1]};
                end
                if (i_dec.acc_mode) n_a = r8;
                else begin n_nwr = 2'd1; n_wd[0] = r8; end
            end
            c6502eu_pkg::OP_JMP: n_npc = i_dec.eff_address;
            c6502eu_pkg::OP_JSR: begin
                ret_pc = i_dec.cur_pc - 16'd1;
                n_nwr = 2'd2;
                n_wa[0] = {c6502eu_pkg::STACK_PAGE, r_sp};
                n_wd[0] = ret_pc[15:8];
                n_wa[1] = {c6502eu_pkg::STACK_PAGE, r_sp - 8'd1};
                n_wd[1] = ret_pc[7:0];
                n_sp = r_sp - 8'd2;
                n_npc = i_dec.eff_address;
            end
            c6502eu_pkg::OP_RTS: begin
                n_sp = r_sp + 8'd2;
                n_npc = {i_dec.s2, i_dec.s1} + 16'd1;
            end
            c6502eu_pkg::OP_BCC: cond = !r_p[c6502eu_pkg::FL_C];
            c6502eu_pkg::OP_BCS: cond = r_p[c6502eu_pkg::FL_C];
            c6502eu_pkg::OP_BEQ: cond = r_p[c6502eu_pkg::FL_Z];
            c6502eu_pkg::OP_BMI: cond = r_p[c6502eu_pkg::FL_N];
            c6502eu_pkg::OP_BNE: cond = !r_p[c6502eu_pkg::FL_Z];
            c6502eu_pkg::OP_BPL: cond = !r_p[c6502eu_pkg::FL_N];
            c6502eu_pkg::OP_BVC: cond = !r_p[c6502eu_pkg::FL_V];
            c6502eu_pkg::OP_BVS: cond = r_p[c6502eu_pkg::FL_V];
            c6502eu_pkg::OP_CLC: n_p[c6502eu_pkg::FL_C] = 1'b0;
            c6502eu_pkg::OP_CLD: n_p[c6502eu_pkg::FL_D] = 1'b0;
            c6502eu_pkg::OP_CLI: n_p[c6502eu_pkg::FL_I] = 1'b0;
            c6502eu_pkg::OP_CLV: n_p[c6502eu_pkg::FL_V] = 1'b0;
            c6502eu_pkg::OP_SEC: n_p[c6502eu_pkg::FL_C] = 1'b1;
            c6502eu_pkg::OP_SED: n_p[c6502eu_pkg::FL_D] = 1'b1;
            c6502eu_pkg::OP_SEI: n_p[c6502eu_pkg::FL_I] = 1'b1;
            c6502eu_pkg::OP_BRK: begin
                ret_pc = i_dec.cur_pc + 16'd1;
                n_nwr = 2'd3;
                n_wa[0] = {c6502eu_pkg::STACK_PAGE, r_sp};
                n_wd[0] = ret_pc[15:8];
                n_wa[1] = {c6502eu_pkg::STACK_PAGE, r_sp - 8'd1};
                n_wd[1] = ret_pc[7:0];
                n_wa[2] = {c6502eu_pkg::STACK_PAGE, r_sp - 8'd2};
                n_wd[2] = r_p | 8'h10;
                n_sp = r_sp - 8'd3;
                n_npc = i_dec.vector;
                n_p = r_p | 8'h04;
            end
            c6502eu_pkg::OP_RTI: begin
                n_sp = r_sp + 8'd3;
                n_p = (i_dec.s1 | 8'h20) & 8'hEF;
                n_npc = {i_dec.s3, i_dec.s2};
            end
            default: ;
        endcase
        // N and Z follow the result byte where the operation sets them
        unique case (i_dec.func)
            c6502eu_pkg::OP_LDA, c6502eu_pkg::OP_LDX, c6502eu_pkg::OP_LDY,
            c6502eu_pkg::OP_TAX, c6502eu_pkg::OP_TAY, c6502eu_pkg::OP_TXA,
            c6502eu_pkg::OP_TYA, c6502eu_pkg::OP_TSX, c6502eu_pkg::OP_PLA,
            c6502eu_pkg::OP_AND, c6502eu_pkg::OP_EOR, c6502eu_pkg::OP_ORA,
            c6502eu_pkg::OP_ADC, c6502eu_pkg::OP_SBC, c6502eu_pkg::OP_CMP,
            c6502eu_pkg::OP_CPX, c6502eu_pkg::OP_CPY, c6502eu_pkg::OP_INC,
            c6502eu_pkg::OP_INX, c6502eu_pkg::OP_INY, c6502eu_pkg::OP_DEC,
            c6502eu_pkg::OP_DEX, c6502eu_pkg::OP_DEY, c6502eu_pkg::OP_ASL,
            c6502eu_pkg::OP_LSR, c6502eu_pkg::OP_ROL, c6502eu_pkg::OP_ROR: begin
                n_p[c6502eu_pkg::FL_Z] = (r8 == 8'd0);
                n_p[c6502eu_pkg::FL_N] = r8[7];
            end
            default: ;
        endcase
        if (i_dec.is_branch && cond) begin
            n_extra = i_dec.page_crossed ? 2'd2 : 2'd1;
            n_npc = i_dec.eff_address;
        end
        if (i_dec.page_crossed && i_dec.page_pen) n_extra = 2'd1;
        if (!i_dec.known) begin
            n_a = r_a; n_x = r_x; n_y = r_y; n_sp = r_sp; n_p = r_p;
            n_nwr = 2'd0; n_npc = i_dec.cur_pc; n_extra = 2'd0;
        end

        n_out = '0;
        if (closing) begin
            n_out.is_last      = 1'b1;
            n_out.next_pc      = n_npc;
            n_out.extra_cycles = n_extra;
            n_out.acc_out      = n_a;
            n_out.x_out        = n_x;
            n_out.y_out        = n_y;
            n_out.sp_out       = n_sp;
            n_out.status_out   = n_p;
        end else begin
            n_out.write_enable  = 1'b1;
            n_out.write_address = n_wa[r_step];
            n_out.write_data    = n_wd[r_step];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a     <= 8'd0;
            r_x     <= 8'd0;
            r_y     <= 8'd0;
            r_sp    <= c6502eu_pkg::SP_RESET;
            r_p     <= c6502eu_pkg::STATUS_RESET;
            r_step  <= 2'd0;
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= have;
            if (have) begin
                r_out <= n_out;
                if (closing) begin
                    r_a <= n_a; r_x <= n_x; r_y <= n_y; r_sp <= n_sp; r_p <= n_p;
                    r_step <= 2'd0;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        have |-> (r_step <= n_nwr)) else $error("write step past item end");
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_out.is_last)) else $error("pop without closing result");
    a_step_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_step == 2'd0)) else $error("step not cleared after item");
`endif
endmodule

// ===== hw/rtl/cpu6502_execute_unit_top.sv =====
// Top level of the 6502 execute unit: front end, two-entry queue, back end.
// Depends on c6502eu_pkg, c6502eu_front, c6502eu_queue, c6502eu_back.
//
// channel  direction  payload               handshake
// in       input      t_in_item (11 fields) i_in_valid / o_in_stall
// out      output     t_out_item (11 fields) o_out_valid / i_out_stall
//
// With an item queued and no stall, the back end sends one result per
// cycle through one output register: each write, then the closing one.
// The queue lets the front end accept new items while the back end works.
// Reset is synchronous; registers return to A=X=Y=0, SP=0xFD, P=0x24.
// A stall on a valid output holds the output register and write step.
module cpu6502_execute_unit_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  c6502eu_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output c6502eu_pkg::t_out_item o_out_item
);
    c6502eu_pkg::t_dec_item push_dec, pop_dec;
    logic push, pop, full, empty;

    c6502eu_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in_valid), .o_stall(o_in_stall),
        .i_item(i_in_item), .o_push(push), .o_dec(push_dec), .i_full(full)
    );

    c6502eu_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(push_dec),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_data(pop_dec)
    );

    c6502eu_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_dec(pop_dec),
        .o_pop(pop), .o_valid(o_out_valid), .i_stall(i_out_stall), .o_item(o_out_item)
    );
endmodule
